// ===== hdl/sha256_pkg.sv =====
// ----------------------------------------------------------------------------
// sha256_pkg
// Shared beat types, controller codes and SHA-256 constants.
// ----------------------------------------------------------------------------
package sha256_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       has_byte;
        logic       is_last;
    } t_in_beat;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_out_beat;

    typedef enum logic [2:0] {
        S_IDLE,
        S_COMP,
        S_ADDH,
        S_PAD80,
        S_PADZ,
        S_LEN,
        S_OUT
    } t_state;

    typedef enum logic [1:0] {
        BYTE_IN,
        BYTE_80,
        BYTE_ZERO,
        BYTE_LEN
    } t_byte_sel;

    typedef struct packed {
        logic      push;
        t_byte_sel sel;
        logic      round;
        logic      addh;
        logic      init;
    } t_cmd;

    typedef struct packed {
        logic [5:0] fill;
        logic       round_last;
    } t_sts;

    localparam logic [7:0] PAD_BYTE   = 8'h80;
    localparam logic [5:0] LEN_OFFSET = 6'd56;
    localparam logic [5:0] FILL_LAST  = 6'd63;
    localparam logic [2:0] WORD_LAST  = 3'd7;

    localparam logic [31:0] ROUND_K [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
        32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
        32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
        32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
        32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
        32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
        32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
        32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
        32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
        32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
        32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] INIT_H [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

endpackage

// ===== hdl/sha256_datapath.sv =====
// ----------------------------------------------------------------------------
// sha256_datapath
// Block shift line, message schedule, one-round-per-cycle compression.
// ----------------------------------------------------------------------------
module sha256_datapath (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  sha256_pkg::t_cmd    i_cmd,
    input  logic [7:0]          i_in_byte,
    input  logic [2:0]          i_out_idx,
    output sha256_pkg::t_sts    o_sts,
    output logic [31:0]         o_word
);

    function automatic logic [31:0] ror(input logic [31:0] x, input int n);
        ror = (x >> n) | (x << (32 - n));
    endfunction

    logic [31:0] r_buf [16];
    logic [31:0] r_h   [8];
    logic [31:0] r_v   [8];
    logic [5:0]  r_fill;
    logic [5:0]  r_round;
    logic [60:0] r_total;

    logic [63:0] len_bits;
    logic [2:0]  len_k;
    logic [7:0]  push_byte;
    logic [31:0] w_new, s0, s1, big0, big1, chs, maj, t1, t2;

    assign len_bits = {r_total, 3'b000};
    assign len_k    = ~r_fill[2:0];

    always_comb begin
        case (i_cmd.sel)
            sha256_pkg::BYTE_IN:   push_byte = i_in_byte;
            sha256_pkg::BYTE_80:   push_byte = sha256_pkg::PAD_BYTE;
            sha256_pkg::BYTE_ZERO: push_byte = 8'h00;
            default:               push_byte = len_bits[{len_k, 3'b000} +: 8];
        endcase
    end

    assign s0    = ror(r_buf[1], 7) ^ ror(r_buf[1], 18) ^ (r_buf[1] >> 3);
    assign s1    = ror(r_buf[14], 17) ^ ror(r_buf[14], 19) ^ (r_buf[14] >> 10);
    assign w_new = r_buf[0] + s0 + r_buf[9] + s1;

    assign big1 = ror(r_v[4], 6) ^ ror(r_v[4], 11) ^ ror(r_v[4], 25);
    assign chs  = (r_v[4] & r_v[5]) ^ (~r_v[4] & r_v[6]);
    assign t1   = r_v[7] + big1 + chs + sha256_pkg::ROUND_K[r_round] + r_buf[0];
    assign big0 = ror(r_v[0], 2) ^ ror(r_v[0], 13) ^ ror(r_v[0], 22);
    assign maj  = (r_v[0] & r_v[1]) ^ (r_v[0] & r_v[2]) ^ (r_v[1] & r_v[2]);
    assign t2   = big0 + maj;

    // Shift line and working variables carry no reset.
    always_ff @(posedge i_clk) begin
        if (i_cmd.push) begin
            for (int i = 0; i < 15; i++) begin
                r_buf[i] <= {r_buf[i][23:0], r_buf[i+1][31:24]};
            end
            r_buf[15] <= {r_buf[15][23:0], push_byte};
            if (r_fill == sha256_pkg::FILL_LAST) begin
                for (int i = 0; i < 8; i++) begin
                    r_v[i] <= r_h[i];
                end
            end
        end else if (i_cmd.round) begin
            for (int i = 0; i < 15; i++) begin
                r_buf[i] <= r_buf[i+1];
            end
            r_buf[15] <= w_new;
            r_v[7] <= r_v[6];
            r_v[6] <= r_v[5];
            r_v[5] <= r_v[4];
            r_v[4] <= r_v[3] + t1;
            r_v[3] <= r_v[2];
            r_v[2] <= r_v[1];
            r_v[1] <= r_v[0];
            r_v[0] <= t1 + t2;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) begin
                r_h[i] <= sha256_pkg::INIT_H[i];
            end
            r_fill  <= '0;
            r_round <= '0;
            r_total <= '0;
        end else begin
            if (i_cmd.push) begin
                r_fill <= r_fill + 6'd1;
            end
            if (i_cmd.push && i_cmd.sel == sha256_pkg::BYTE_IN) begin
                r_total <= r_total + 61'd1;
            end
            if (i_cmd.round) begin
                r_round <= r_round + 6'd1;
            end
            if (i_cmd.addh) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= r_h[i] + r_v[i];
                end
            end else if (i_cmd.init) begin
                for (int i = 0; i < 8; i++) begin
                    r_h[i] <= sha256_pkg::INIT_H[i];
                end
                r_total <= '0;
            end
        end
    end

    assign o_sts.fill       = r_fill;
    assign o_sts.round_last = (r_round == 6'd63);
    assign o_word           = r_h[i_out_idx];

endmodule

// ===== hdl/sha256_ctrl.sv =====
// ----------------------------------------------------------------------------
// sha256_ctrl
// Sequencer for byte intake, padding, compression and digest output.
// ----------------------------------------------------------------------------
module sha256_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  logic                i_has_byte,
    input  logic                i_is_last,
    input  logic                i_out_stall,
    input  sha256_pkg::t_sts    i_sts,
    output sha256_pkg::t_cmd    o_cmd,
    output logic                o_in_stall,
    output logic                o_out_valid,
    output logic [2:0]          o_out_idx
);

    sha256_pkg::t_state r_state, n_state;
    logic       r_fin, n_fin;
    logic       r_p80, n_p80;
    logic       r_len, n_len;
    logic [2:0] r_oidx, n_oidx;
    logic       full;

    assign full = (i_sts.fill == sha256_pkg::FILL_LAST);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha256_pkg::S_IDLE;
            r_fin   <= 1'b0;
            r_p80   <= 1'b0;
            r_len   <= 1'b0;
            r_oidx  <= '0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
            r_p80   <= n_p80;
            r_len   <= n_len;
            r_oidx  <= n_oidx;
        end
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        n_fin   = r_fin;
        n_p80   = r_p80;
        n_len   = r_len;
        n_oidx  = r_oidx;
        unique case (r_state)
            sha256_pkg::S_IDLE: begin
                if (i_in_valid) begin
                    n_fin = i_is_last;
                    if (i_has_byte && full) begin
                        n_state = sha256_pkg::S_COMP;
                    end else if (i_is_last) begin
                        n_state = sha256_pkg::S_PAD80;
                    end
                end
            end
            sha256_pkg::S_COMP: begin
                if (i_sts.round_last) begin
                    n_state = sha256_pkg::S_ADDH;
                end
            end
            sha256_pkg::S_ADDH: begin
                if (!r_fin) begin
                    n_state = sha256_pkg::S_IDLE;
                end else if (r_len) begin
                    n_state = sha256_pkg::S_OUT;
                end else if (r_p80) begin
                    n_state = sha256_pkg::S_PADZ;
                end else begin
                    n_state = sha256_pkg::S_PAD80;
                end
            end
            sha256_pkg::S_PAD80: begin
                n_p80   = 1'b1;
                n_state = full ? sha256_pkg::S_COMP : sha256_pkg::S_PADZ;
            end
            sha256_pkg::S_PADZ: begin
                if (i_sts.fill == sha256_pkg::LEN_OFFSET) begin
                    n_state = sha256_pkg::S_LEN;
                end else if (full) begin
                    n_state = sha256_pkg::S_COMP;
                end
            end
            sha256_pkg::S_LEN: begin
                if (full) begin
                    n_len   = 1'b1;
                    n_state = sha256_pkg::S_COMP;
                end
            end
            sha256_pkg::S_OUT: begin
                if (!i_out_stall) begin
                    n_oidx = r_oidx + 3'd1;
                    if (r_oidx == sha256_pkg::WORD_LAST) begin
                        n_state = sha256_pkg::S_IDLE;
                        n_fin   = 1'b0;
                        n_p80   = 1'b0;
                        n_len   = 1'b0;
                    end
                end
            end
            default: n_state = sha256_pkg::S_IDLE;
        endcase
    end

    // Outputs.
    always_comb begin
        o_cmd      = '0;
        o_cmd.sel  = sha256_pkg::BYTE_IN;
        unique case (r_state)
            sha256_pkg::S_IDLE: begin
                o_cmd.push = i_in_valid && i_has_byte;
            end
            sha256_pkg::S_COMP:  o_cmd.round = 1'b1;
            sha256_pkg::S_ADDH:  o_cmd.addh  = 1'b1;
            sha256_pkg::S_PAD80: begin
                o_cmd.push = 1'b1;
                o_cmd.sel  = sha256_pkg::BYTE_80;
            end
            sha256_pkg::S_PADZ: begin
                o_cmd.push = (i_sts.fill != sha256_pkg::LEN_OFFSET);
                o_cmd.sel  = sha256_pkg::BYTE_ZERO;
            end
            sha256_pkg::S_LEN: begin
                o_cmd.push = 1'b1;
                o_cmd.sel  = sha256_pkg::BYTE_LEN;
            end
            sha256_pkg::S_OUT: begin
                o_cmd.init = !i_out_stall && (r_oidx == sha256_pkg::WORD_LAST);
            end
            default: o_cmd = '0;
        endcase
    end

    assign o_in_stall  = (r_state != sha256_pkg::S_IDLE);
    assign o_out_valid = (r_state == sha256_pkg::S_OUT);
    assign o_out_idx   = r_oidx;

`ifndef NO_ASSERTIONS
    a_round_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.round |-> (i_sts.fill == 6'd0))
        else $error("round issued with bytes in buffer");
    a_push_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.push |-> !(o_cmd.round || o_cmd.addh || o_cmd.init))
        else $error("push overlaps another command");
    a_done_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sha256_pkg::S_ADDH && r_fin && r_len) |=> o_out_valid)
        else $error("digest not presented after final block");
`endif

endmodule

// ===== hdl/sha256_stream_hasher_unit.sv =====
// ----------------------------------------------------------------------------
// sha256_stream_hasher_unit
// Streaming SHA-256 hasher, at most one message byte per input beat.
// ----------------------------------------------------------------------------
// Input channel: i_in_valid / o_in_stall carry a t_in_beat. A beat may hold
// one byte (has_byte) and may end the message (is_last).
// Output channel: o_out_valid / i_out_stall carry eight t_out_beat words,
// word 0 first, last_word set on word 7.
// Throughput: a byte beat is taken each cycle while idle; every 64th byte
// then holds the input for the 64 rounds of the single round unit plus the
// hash update before the next byte is taken.
// After a last beat, padding pushes one byte a cycle up to the end of the
// block, pausing once at the length offset, and each block is compressed
// (one or two) with the hash update, then the digest words leave one per cycle
// while the receiver does not stall.
// A stall holds the current digest word; the block takes no new input
// beat until the eighth word has left. Then the hash returns to the
// initial value and a new message starts.
// Reset clears the controller, the byte count and restores the initial
// hash value.
// ----------------------------------------------------------------------------
module sha256_stream_hasher_unit (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_in_valid,
    input  sha256_pkg::t_in_beat     i_in_data,
    output logic                     o_in_stall,
    output logic                     o_out_valid,
    output sha256_pkg::t_out_beat    o_out_data,
    input  logic                     i_out_stall
);

    sha256_pkg::t_cmd cmd;
    sha256_pkg::t_sts sts;
    logic [2:0]       out_idx;
    logic [31:0]      word;

    // Sequence intake, padding, rounds and output.
    sha256_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_has_byte  (i_in_data.has_byte),
        .i_is_last   (i_in_data.is_last),
        .i_out_stall (i_out_stall),
        .i_sts       (sts),
        .o_cmd       (cmd),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_idx   (out_idx)
    );

    // Hold block bytes, schedule and hash state.
    sha256_datapath u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd     (cmd),
        .i_in_byte (i_in_data.data_byte),
        .i_out_idx (out_idx),
        .o_sts     (sts),
        .o_word    (word)
    );

    assign o_out_data.digest_word = word;
    assign o_out_data.word_index  = out_idx;
    assign o_out_data.last_word   = (out_idx == sha256_pkg::WORD_LAST);

endmodule

// ===== dv/sha256_digest_checker.sv =====
// ----------------------------------------------------------------------------
// sha256_digest_checker
// Watches both channels, hashes the accepted byte stream with its own
// SHA-256 model and compares every digest beat with the predicted word.
// ----------------------------------------------------------------------------
module sha256_digest_checker (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    input  sha256_pkg::t_in_beat  i_in_data,
    input  logic                  i_in_stall,
    input  logic                  i_out_valid,
    input  sha256_pkg::t_out_beat i_out_data,
    input  logic                  i_out_stall,
    output int                    o_fail_count,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    logic [31:0]           hash_h [8];
    logic [7:0]            msg_block [64];
    int                    block_fill;
    logic [60:0]           msg_bytes;
    sha256_pkg::t_out_beat digest_q [$];

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        return (x >> n) | (x << (32 - n));
    endfunction

    task automatic compress_msg_block();
        logic [31:0] w [64];
        logic [31:0] v [8];
        logic [31:0] t1, t2;
        for (int i = 0; i < 16; i++)
            w[i] = {msg_block[4*i], msg_block[4*i+1], msg_block[4*i+2], msg_block[4*i+3]};
        for (int i = 16; i < 64; i++)
            w[i] = w[i-16] + w[i-7]
                 + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3))
                 + (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10));
        for (int i = 0; i < 8; i++) v[i] = hash_h[i];
        for (int i = 0; i < 64; i++) begin
            t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
               + ((v[4] & v[5]) ^ (~v[4] & v[6])) + sha256_pkg::ROUND_K[i] + w[i];
            t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
               + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
            v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
            v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
        end
        for (int i = 0; i < 8; i++) hash_h[i] += v[i];
    endtask

    task automatic append_byte(input logic [7:0] b);
        msg_block[block_fill] = b;
        block_fill++;
        if (block_fill == 64) begin
            compress_msg_block();
            block_fill = 0;
        end
    endtask

    task automatic absorb_beat(input sha256_pkg::t_in_beat beat);
        logic [63:0]           bit_len;
        sha256_pkg::t_out_beat word;
        if (beat.has_byte) begin
            append_byte(beat.data_byte);
            msg_bytes++;
        end
        if (beat.is_last) begin
            bit_len = {msg_bytes, 3'b000};
            append_byte(sha256_pkg::PAD_BYTE);
            while (block_fill != sha256_pkg::LEN_OFFSET) append_byte(8'h00);
            for (int i = 0; i < 8; i++) append_byte(bit_len[63 - 8*i -: 8]);
            for (int i = 0; i < 8; i++) begin
                word.digest_word = hash_h[i];
                word.word_index  = 3'(i);
                word.last_word   = (3'(i) == sha256_pkg::WORD_LAST);
                digest_q = {digest_q, word};
            end
            for (int i = 0; i < 8; i++) hash_h[i] = sha256_pkg::INIT_H[i];
            msg_bytes = '0;
        end
    endtask

    always @(posedge i_clk) begin
        sha256_pkg::t_out_beat exp_word;
        if (!i_rst_n) begin
            for (int i = 0; i < 8; i++) hash_h[i] = sha256_pkg::INIT_H[i];
            block_fill = 0;
            msg_bytes = '0;
            digest_q.delete();
            o_fail_count = 0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                if (digest_q.size() == 0) begin
                    o_fail_count++;
                    $display("%0t: unexpected digest beat %h", $time, i_out_data);
                end else begin
                    exp_word = digest_q.pop_front();
                    if (i_out_data.digest_word !== exp_word.digest_word ||
                        i_out_data.word_index !== exp_word.word_index ||
                        i_out_data.last_word !== exp_word.last_word) begin
                        o_fail_count++;
                        $display("%0t: digest mismatch expected %h/%0d/%b actual %h/%0d/%b",
                                 $time, exp_word.digest_word, exp_word.word_index,
                                 exp_word.last_word, i_out_data.digest_word,
                                 i_out_data.word_index, i_out_data.last_word);
                    end
                end
            end
            if (i_in_valid && !i_in_stall) absorb_beat(i_in_data);
        end
        o_pending = digest_q.size();
    end
endmodule

// ===== dv/tb_sha256_stream_hasher_unit.sv =====
// ----------------------------------------------------------------------------
// tb_sha256_stream_hasher_unit
// Streams byte beats into the hasher with random gaps and output stalls;
// the checker predicts each digest and counts mismatches.
// ----------------------------------------------------------------------------
module tb_sha256_stream_hasher_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int IDLE_LIMIT = 20000;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    sha256_pkg::t_in_beat  in_data;
    logic                  in_stall;
    logic                  out_valid;
    sha256_pkg::t_out_beat out_data;
    logic                  out_stall;
    int                    fail_count;
    int                    pending;
    int                    idle_cycles;
    bit                    calm_mode;   // no gaps and no stalls while set

    sha256_stream_hasher_unit dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    sha256_digest_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_data    (in_data),
        .i_in_stall   (in_stall),
        .i_out_valid  (out_valid),
        .i_out_data   (out_data),
        .i_out_stall  (out_stall),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Receiver: stall about 14 beats in 100 unless in a calm stretch.
    always @(posedge clk) begin
        if (!rst_n) begin
            out_stall <= 1'b0;
        end else begin
            out_stall <= !calm_mode && ($urandom_range(99) < 14);
        end
    end

    // Watchdog: count cycles with no beat accepted on either side.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || !rst_n) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // Drive one beat, with an optional random gap first; wait for acceptance.
    task automatic send_beat(input logic [7:0] b, input logic has, input logic last);
        if (!calm_mode) begin
            while ($urandom_range(99) < 14) begin
                in_valid <= 1'b0;
                @(posedge clk);
            end
        end
        in_valid <= 1'b1;
        in_data  <= '{data_byte: b, has_byte: has, is_last: last};
        @(posedge clk);
        while (in_stall) @(posedge clk);
    endtask

    // Send a message of n random bytes; the final byte may ride on the last beat.
    task automatic send_message(input int n, input bit byte_on_last);
        int body;
        body = (byte_on_last && n > 0) ? n - 1 : n;
        for (int i = 0; i < body; i++)
            send_beat(8'($urandom), 1'b1, 1'b0);
        if (byte_on_last && n > 0) send_beat(8'($urandom), 1'b1, 1'b1);
        else send_beat(8'($urandom), 1'b0, 1'b1);
    endtask

    initial begin
        int sent;
        int len;
        int lens [3];
        bit on_last;
        calm_mode   = 1'b0;
        idle_cycles = 0;
        rst_n       = 1'b0;
        in_valid    = 1'b0;
        in_data     = '0;
        out_stall   = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty messages back to back, extreme bytes, ignored byte bits.
        send_beat(8'hff, 1'b0, 1'b1);
        send_beat(8'h00, 1'b0, 1'b1);
        send_beat(8'h00, 1'b1, 1'b0);
        send_beat(8'hff, 1'b1, 1'b0);
        send_beat(8'haa, 1'b0, 1'b0);
        send_beat(8'h55, 1'b1, 1'b1);
        send_beat(8'h80, 1'b1, 1'b1);
        // Hold until every digest word has drained.
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);

        // Padding boundaries: 56 overflows, 63 fills the block with the pad
        // byte, 64 ends on a full block with the byte on the last beat.
        // The middle message runs without gaps or stalls.
        sent = 7;
        lens = '{56, 63, 64};
        for (int k = 0; k < 3; k++) begin
            calm_mode = (k == 1);
            on_last   = (lens[k] != 63);
            send_message(lens[k], on_last);
            sent += on_last ? lens[k] : lens[k] + 1;
        end
        calm_mode = 1'b0;

        // Random messages, mostly short.
        while (sent < 230) begin
            len = ($urandom_range(9) == 0) ? $urandom_range(70) : $urandom_range(12);
            on_last = 1'($urandom_range(1));
            send_message(len, on_last);
            sent += (on_last && len > 0) ? len : len + 1;
            if ($urandom_range(15) == 0) begin
                send_beat(8'($urandom), 1'b0, 1'b0);
                sent++;
            end
        end
        in_valid <= 1'b0;

        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        if (fail_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
